// File: rtl/csc_pkg.sv
// csc_pkg: shared constants and register codes for the cross stencil star counter
// no dependencies; imported by cross_stencil_star_counter
`default_nettype none

package csc_pkg;

	// default sizes handed to the top level parameters
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_PIXEL_BITS = 8;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 11;
	localparam int THRESH_W    = 8;
	// five times the threshold
	localparam int THR5_W      = THRESH_W + 3;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MEAN_THRESHOLD = 2'd2;

	// register reset values
	localparam int RST_IMAGE_WIDTH    = 8;
	localparam int RST_IMAGE_HEIGHT   = 6;
	localparam int RST_MEAN_THRESHOLD = 6;

	// smallest legal image side
	localparam int MIN_SIDE = 3;

	// result fields
	localparam int POS_OUT_W = 10;
	localparam int COUNT_W   = 20;

endpackage

`default_nettype wire

// File: rtl/csc_ram.sv
// csc_ram: generic synchronous ram, one write port and two registered read ports
// no dependencies; used for the line stores of cross_stencil_star_counter
`default_nettype none

module csc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read ports, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

// File: rtl/cross_stencil_star_counter.sv
// cross_stencil_star_counter: top level, five-point cross star detector and counter
// depends on csc_pkg and csc_ram
`default_nettype none

// Pixels enter in raster order, one per clock while out_stall is low, and every pixel
// gives one result item, registered in stage 1 and then in the output register. The
// rate is set by the line store ram, which serves one read of two column words and
// one write-back of a column word per pixel. Each ram word holds the two rows above the
// current one for one column, so the store is MAX_WIDTH words of 2*PIXEL_BITS bits and
// needs no clearing after reset. A result marks a star when the centre and its four
// cross neighbours sum to more than five times mean_threshold; the star count restarts
// at the first pixel of every frame and saturates at 2^20-1. Width and height are
// clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT and should only be written while idle.
module cross_stencil_star_counter
	import csc_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// pixel input
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [PIXEL_BITS-1:0]  pixel_value,
	// result output
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        star_hit,
	output logic                        valid_centre,
	output logic [POS_OUT_W-1:0]        centre_row,
	output logic [POS_OUT_W-1:0]        centre_col,
	output logic [PIXEL_BITS-1:0]       centre_value,
	output logic [COUNT_W-1:0]          star_total,
	output logic                        frame_end
);

	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int SUM_W = PIXEL_BITS + 3;
	localparam int CMP_W = (SUM_W > THR5_W) ? SUM_W : THR5_W;
	localparam int RST_W = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
	localparam int RST_H = (RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_IMAGE_HEIGHT;
	localparam int RAM_W = 2 * PIXEL_BITS;

	// configuration registers, sizes kept clamped
	logic [WW-1:0]       width_q;
	logic [HW-1:0]       height_q;
	logic [THRESH_W-1:0] thresh_q;
	logic [31:0]         cfg_ext;
	logic [WW-1:0]       width_clamped;
	logic [HW-1:0]       height_clamped;

	// raster position of the next pixel
	logic [AW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [WW-1:0] col_ext;
	logic [HW-1:0] row_ext;
	logic          last_col;
	logic          last_row;
	logic          interior;
	logic          frame_start;
	logic          accept;

	// stage 1: ram data arrives
	logic                  valid_s1;
	logic [AW-1:0]         col_s1;
	logic [RW-1:0]         row_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic                  interior_s1;
	logic                  frame_end_s1;
	logic                  start_s1;
	logic                  advance_s1;

	// left neighbour: centre value of the previous item
	logic [PIXEL_BITS-1:0] left_q;
	logic [COUNT_W-1:0]    star_count_q;

	// line store ram
	logic                  ram_we;
	logic                  ram_re;
	logic [AW-1:0]         ram_waddr;
	logic [RAM_W-1:0]      ram_wdata;
	logic [AW-1:0]         ram_raddr_a;
	logic [AW-1:0]         ram_raddr_b;
	logic [RAM_W-1:0]      ram_rdata_a;
	logic [RAM_W-1:0]      ram_rdata_b;

	// stencil arithmetic
	logic [PIXEL_BITS-1:0] top_v;
	logic [PIXEL_BITS-1:0] centre_v;
	logic [PIXEL_BITS-1:0] right_v;
	logic [SUM_W-1:0]      cross_sum;
	logic [CMP_W-1:0]      thresh5;
	logic                  hit;
	logic [COUNT_W-1:0]    count_base;
	logic [COUNT_W-1:0]    count_next;

	// stage 2: output register
	logic                  valid_s2;
	logic                  star_hit_s2;
	logic                  valid_centre_s2;
	logic [POS_OUT_W-1:0]  centre_row_s2;
	logic [POS_OUT_W-1:0]  centre_col_s2;
	logic [PIXEL_BITS-1:0] centre_value_s2;
	logic [COUNT_W-1:0]    star_total_s2;
	logic                  frame_end_s2;

	// size clamping on the write data
	assign cfg_ext = 32'(cfg_data);
	always_comb begin
		if (cfg_ext < 32'(MIN_SIDE)) begin
			width_clamped = WW'(MIN_SIDE);
		end else if (cfg_ext > 32'(MAX_WIDTH)) begin
			width_clamped = WW'(MAX_WIDTH);
		end else begin
			width_clamped = WW'(cfg_ext);
		end
		if (cfg_ext < 32'(MIN_SIDE)) begin
			height_clamped = HW'(MIN_SIDE);
		end else if (cfg_ext > 32'(MAX_HEIGHT)) begin
			height_clamped = HW'(MAX_HEIGHT);
		end else begin
			height_clamped = HW'(cfg_ext);
		end
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(RST_W);
			height_q <= HW'(RST_H);
			thresh_q <= THRESH_W'(RST_MEAN_THRESHOLD);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:    width_q  <= width_clamped;
				REG_IMAGE_HEIGHT:   height_q <= height_clamped;
				REG_MEAN_THRESHOLD: thresh_q <= cfg_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// position decode for the incoming item
	assign col_ext     = WW'(col_q);
	assign row_ext     = HW'(row_q);
	assign last_col    = col_ext >= (width_q - WW'(1));
	assign last_row    = row_ext >= (height_q - HW'(1));
	assign interior    = (row_q >= RW'(2)) && (col_q != '0) && (col_ext <= (width_q - WW'(2)));
	assign frame_start = (row_q == '0) && (col_q == '0);

	// handshake: stage 1 drains into the output register
	assign advance_s1 = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall   = valid_s1 && !advance_s1;
	assign accept     = in_valid && !in_stall;

	// raster position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// read this column and the next one
	assign ram_re      = accept;
	assign ram_raddr_a = col_q;
	assign ram_raddr_b = (col_q == AW'(MAX_WIDTH - 1)) ? col_q : col_q + AW'(1);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1       <= col_q;
			row_s1       <= row_q;
			pix_s1       <= pixel_value;
			interior_s1  <= interior;
			frame_end_s1 <= last_col && last_row;
			start_s1     <= frame_start;
		end
	end

	csc_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	// word layout: upper row in the high half, middle row in the low half
	assign top_v    = ram_rdata_a[RAM_W-1:PIXEL_BITS];
	assign centre_v = ram_rdata_a[PIXEL_BITS-1:0];
	assign right_v  = ram_rdata_b[PIXEL_BITS-1:0];

	// shift the column down one row on the way out of stage 1
	assign ram_we    = advance_s1;
	assign ram_waddr = col_s1;
	assign ram_wdata = {centre_v, pix_s1};

	// cross sum against five times the threshold
	assign cross_sum = SUM_W'(left_q) + SUM_W'(top_v) + SUM_W'(right_v)
		+ SUM_W'(centre_v) + SUM_W'(pix_s1);
	assign thresh5 = CMP_W'({thresh_q, 2'b00}) + CMP_W'(thresh_q);
	assign hit     = interior_s1 && (CMP_W'(cross_sum) > thresh5);

	// per-frame star count, saturating
	assign count_base = start_s1 ? '0 : star_count_q;
	assign count_next = (hit && (count_base != '1)) ? count_base + COUNT_W'(1) : count_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			star_count_q <= '0;
		end else if (advance_s1) begin
			star_count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			left_q <= centre_v;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// output register payload, centre fields zero off the interior
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			star_hit_s2     <= hit;
			valid_centre_s2 <= interior_s1;
			centre_row_s2   <= interior_s1 ? POS_OUT_W'(row_s1 - RW'(1)) : '0;
			centre_col_s2   <= interior_s1 ? POS_OUT_W'(col_s1) : '0;
			centre_value_s2 <= interior_s1 ? centre_v : '0;
			star_total_s2   <= count_next;
			frame_end_s2    <= frame_end_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign star_hit     = star_hit_s2;
	assign valid_centre = valid_centre_s2;
	assign centre_row   = centre_row_s2;
	assign centre_col   = centre_col_s2;
	assign centre_value = centre_value_s2;
	assign star_total   = star_total_s2;
	assign frame_end    = frame_end_s2;

	// a star is only ever reported for an interior centre
	a_hit_needs_centre: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && star_hit_s2 |-> valid_centre_s2)
		else $error("star reported without an interior centre");

	// the write-back never lands on a column being read in the same cycle
	a_ram_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> (ram_waddr != ram_raddr_a) && (ram_waddr != ram_raddr_b))
		else $error("line store write collides with a read");

	// within a frame the star count never goes down
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && !start_s1 |=> star_count_q >= $past(star_count_q))
		else $error("star count decreased inside a frame");

endmodule

`default_nettype wire
